FILE: rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude stream.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_HEIGHT   = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int PIX_W        = 8;
   localparam int GRAD_W       = PIX_W + 3;
   localparam int OWED_W       = 23;
   localparam int RSP_DEPTH    = 4;
   localparam int PEND_W       = $clog2(RSP_DEPTH + 1);
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic             func;
      logic [PIX_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_value;
      logic [11:0]      out_row;
      logic [10:0]      out_col;
      logic             last_of_frame;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] px;
   } line_ctrl_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
   } grad_type;

endpackage

FILE: rtl/sem_line_window.sv
// ----------------------------------------------------------------------------
// sem_line_window
// Line memory holding the two previous rows, 3x3 window and Sobel gradients.
// ----------------------------------------------------------------------------
module sem_line_window (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [sem_pkg::COL_W-1:0]   rd_addr,
   input  sem_pkg::line_ctrl_type      ctrl,
   output sem_pkg::grad_type           grad
);

   // Each entry holds {upper row, middle row} for one column.
   logic [2*sem_pkg::PIX_W-1:0] line_mem [sem_pkg::MAX_WIDTH];
   logic [2*sem_pkg::PIX_W-1:0] rd_ff;
   logic [sem_pkg::PIX_W-1:0]   window_ff [3][3];
   logic [sem_pkg::PIX_W-1:0]   window_in [3][3];
   sem_pkg::grad_type           grad_ff;
   sem_pkg::grad_type           grad_in;

   function automatic logic signed [sem_pkg::GRAD_W-1:0] grad3(
      input logic [sem_pkg::PIX_W-1:0] a,
      input logic [sem_pkg::PIX_W-1:0] b,
      input logic [sem_pkg::PIX_W-1:0] c,
      input logic [sem_pkg::PIX_W-1:0] d,
      input logic [sem_pkg::PIX_W-1:0] e,
      input logic [sem_pkg::PIX_W-1:0] f
   );
      logic [sem_pkg::GRAD_W-1:0] pos;
      logic [sem_pkg::GRAD_W-1:0] neg;
      pos = sem_pkg::GRAD_W'(a) + (sem_pkg::GRAD_W'(b) << 1) + sem_pkg::GRAD_W'(c);
      neg = sem_pkg::GRAD_W'(d) + (sem_pkg::GRAD_W'(e) << 1) + sem_pkg::GRAD_W'(f);
      return signed'(pos - neg);
   endfunction

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= line_mem[rd_addr];
      end
   end

   // Consecutive pixels never share a column, so the write-back never meets
   // a read of the same entry.
   always_ff @(posedge clock) begin
      if (ctrl.valid) begin
         line_mem[ctrl.addr] <= {rd_ff[sem_pkg::PIX_W-1:0], ctrl.px};
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         window_in[k][0] = window_ff[k][0];
         window_in[k][1] = window_ff[k][1];
         window_in[k][2] = window_ff[k][2];
      end
      if (ctrl.valid) begin
         for (int k = 0; k < 3; k++) begin
            window_in[k][0] = window_ff[k][1];
            window_in[k][1] = window_ff[k][2];
         end
         window_in[0][2] = rd_ff[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];
         window_in[1][2] = rd_ff[sem_pkg::PIX_W-1:0];
         window_in[2][2] = ctrl.px;
      end
      grad_in.gx = grad3(window_in[0][0], window_in[1][0], window_in[2][0],
                         window_in[0][2], window_in[1][2], window_in[2][2]);
      grad_in.gy = grad3(window_in[0][0], window_in[0][1], window_in[0][2],
                         window_in[2][0], window_in[2][1], window_in[2][2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               window_ff[k][j] <= '0;
            end
         end
      end else begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      grad_ff <= grad_in;
   end

   assign grad = grad_ff;

endmodule

FILE: rtl/sem_rsp_fifo.sv
// ----------------------------------------------------------------------------
// sem_rsp_fifo
// Small result queue that decouples the pipeline from the result channel.
// ----------------------------------------------------------------------------
module sem_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sem_pkg::rsp_type push_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sem_pkg::rsp_type rsp_data
);

   localparam int PTR_W = $clog2(sem_pkg::RSP_DEPTH);

   sem_pkg::rsp_type          slot_ff [sem_pkg::RSP_DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff;
   logic [PTR_W-1:0]          wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff;
   logic [PTR_W-1:0]          rd_ptr_in;
   logic [sem_pkg::PEND_W-1:0] count_ff;
   logic [sem_pkg::PEND_W-1:0] count_in;
   logic                      pop;

   always_comb begin
      pop       = (count_ff != '0) && !rsp_stall;
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + sem_pkg::PEND_W'(1);
         2'b01:   count_in = count_ff - sem_pkg::PEND_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];

endmodule

FILE: rtl/sobel_edge_magnitude_stream_top.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_stream_top
// Streaming 3x3 Sobel L1 edge magnitude over a raster-order pixel stream.
// Throughput: one item per cycle while a result slot is free (else req_stall),
// set by the line memory read at acceptance and its write-back in the next cycle.
// A result passes the s1 and s2 tag registers and the queue before it transfers.
// Reset is synchronous: counters, window and result queue are cleared, the
// size registers return to 640 by 480; the line memory is not cleared.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_stream_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sem_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sem_pkg::rsp_type                 rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sem_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sem_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sem_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   typedef struct packed {
      logic        emit;
      logic        use_window;
      logic [11:0] row;
      logic [10:0] col;
      logic        last;
   } tag_type;

   localparam logic [sem_pkg::WIDTH_REG_W-1:0]  W_MAX =
      sem_pkg::WIDTH_REG_W'(sem_pkg::MAX_WIDTH);
   localparam logic [sem_pkg::HEIGHT_REG_W-1:0] H_MAX =
      sem_pkg::HEIGHT_REG_W'(sem_pkg::MAX_HEIGHT);
   localparam logic [sem_pkg::OWED_W-1:0]       OWED_MAX = '1;

   logic [sem_pkg::WIDTH_REG_W-1:0]  frame_width_ff;
   logic [sem_pkg::WIDTH_REG_W-1:0]  frame_width_in;
   logic [sem_pkg::HEIGHT_REG_W-1:0] frame_height_ff;
   logic [sem_pkg::HEIGHT_REG_W-1:0] frame_height_in;
   logic [sem_pkg::WIDTH_REG_W-1:0]  w_eff;
   logic [sem_pkg::HEIGHT_REG_W-1:0] h_eff;
   sem_pkg::csr_index_type           csr_index;
   logic                             csr_write;

   logic [sem_pkg::COL_W-1:0]  in_col_ff;
   logic [sem_pkg::COL_W-1:0]  in_col_in;
   logic [11:0]                out_row_ff;
   logic [11:0]                out_row_in;
   logic [10:0]                out_col_ff;
   logic [10:0]                out_col_in;
   logic [sem_pkg::OWED_W-1:0] owed_ff;
   logic [sem_pkg::OWED_W-1:0] owed_in;
   logic [sem_pkg::OWED_W-1:0] owed_inc;
   logic [sem_pkg::PEND_W-1:0] pending_ff;
   logic [sem_pkg::PEND_W-1:0] pending_in;

   logic                   accept;
   logic                   emit;
   logic                   interior;
   logic                   rsp_pop;
   tag_type                tag_in;
   tag_type                s1_tag_ff;
   tag_type                s2_tag_ff;
   sem_pkg::line_ctrl_type s1_line_ff;
   sem_pkg::line_ctrl_type s1_line_in;
   sem_pkg::grad_type      grad;

   logic [sem_pkg::GRAD_W-1:0] abs_gx;
   logic [sem_pkg::GRAD_W-1:0] abs_gy;
   logic [sem_pkg::GRAD_W-1:0] mag_sum;
   logic [sem_pkg::PIX_W-1:0]  mag_clamped;
   logic                       push;
   sem_pkg::rsp_type           push_data;

   // Configuration port.
   always_comb begin
      csr_index       = sem_pkg::csr_index_type'(csr_paddr[2]);
      csr_write       = csr_psel && csr_penable && csr_pwrite && csr_pready;
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      unique case (csr_index)
         sem_pkg::CSR_FRAME_WIDTH: begin
            csr_prdata = sem_pkg::CSR_DATA_W'(frame_width_ff);
            if (csr_write) begin
               frame_width_in = csr_pwdata[sem_pkg::WIDTH_REG_W-1:0];
            end
         end
         sem_pkg::CSR_FRAME_HEIGHT: begin
            csr_prdata = sem_pkg::CSR_DATA_W'(frame_height_ff);
            if (csr_write) begin
               frame_height_in = csr_pwdata[sem_pkg::HEIGHT_REG_W-1:0];
            end
         end
      endcase
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= sem_pkg::WIDTH_REG_W'(640);
         frame_height_ff <= sem_pkg::HEIGHT_REG_W'(480);
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   always_comb begin
      priority if (frame_width_ff < sem_pkg::WIDTH_REG_W'(3)) begin
         w_eff = sem_pkg::WIDTH_REG_W'(3);
      end else if (frame_width_ff > W_MAX) begin
         w_eff = W_MAX;
      end else begin
         w_eff = frame_width_ff;
      end
      priority if (frame_height_ff < sem_pkg::HEIGHT_REG_W'(3)) begin
         h_eff = sem_pkg::HEIGHT_REG_W'(3);
      end else if (frame_height_ff > H_MAX) begin
         h_eff = H_MAX;
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // Acceptance stage: position bookkeeping and the decision to emit.
   assign req_stall = (pending_ff == sem_pkg::PEND_W'(sem_pkg::RSP_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      owed_inc   = (owed_ff < OWED_MAX) ? owed_ff + sem_pkg::OWED_W'(1) : owed_ff;
      emit       = 1'b0;
      owed_in    = owed_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      s1_line_in = '{valid: 1'b0, addr: in_col_ff, px: req_data.pixel};
      interior   = (out_row_ff != '0)
                && (({1'b0, out_row_ff} + 13'd2) <= h_eff)
                && (out_col_ff != '0)
                && (({1'b0, out_col_ff} + 12'd2) <= w_eff);
      if (accept) begin
         if (req_data.func == sem_pkg::FUNC_DRAIN) begin
            if (owed_ff != '0) begin
               emit    = 1'b1;
               owed_in = owed_ff - sem_pkg::OWED_W'(1);
            end
         end else begin
            s1_line_in.valid = 1'b1;
            if (({1'b0, in_col_ff} + 12'd1) >= w_eff) begin
               in_col_in = '0;
            end else begin
               in_col_in = in_col_ff + sem_pkg::COL_W'(1);
            end
            emit    = owed_inc > (sem_pkg::OWED_W'(w_eff) + sem_pkg::OWED_W'(1));
            owed_in = emit ? owed_inc - sem_pkg::OWED_W'(1) : owed_inc;
         end
         if (emit) begin
            if (({1'b0, out_col_ff} + 12'd1) >= w_eff) begin
               out_col_in = '0;
               if (({1'b0, out_row_ff} + 13'd1) >= h_eff) begin
                  out_row_in = '0;
               end else begin
                  out_row_in = out_row_ff + 12'd1;
               end
            end else begin
               out_col_in = out_col_ff + 11'd1;
            end
         end
      end
      tag_in.emit       = emit;
      tag_in.use_window = interior && (req_data.func == sem_pkg::FUNC_PIXEL);
      tag_in.row        = out_row_ff;
      tag_in.col        = out_col_ff;
      tag_in.last       = (({1'b0, out_row_ff} + 13'd1) >= h_eff)
                       && (({1'b0, out_col_ff} + 12'd1) >= w_eff);
   end

   assign rsp_pop = rsp_valid && !rsp_stall;

   always_comb begin
      unique case ({accept && emit, rsp_pop})
         2'b10:   pending_in = pending_ff + sem_pkg::PEND_W'(1);
         2'b01:   pending_in = pending_ff - sem_pkg::PEND_W'(1);
         default: pending_in = pending_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         owed_ff    <= '0;
         pending_ff <= '0;
         s1_tag_ff  <= '0;
         s2_tag_ff  <= '0;
         s1_line_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         owed_ff    <= owed_in;
         pending_ff <= pending_in;
         s1_tag_ff  <= tag_in;
         s2_tag_ff  <= s1_tag_ff;
         s1_line_ff <= s1_line_in;
      end
   end

   sem_line_window u_line_window (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (s1_line_in.valid),
      .rd_addr (in_col_ff),
      .ctrl    (s1_line_ff),
      .grad    (grad)
   );

   // Magnitude stage.
   always_comb begin
      abs_gx      = grad.gx[sem_pkg::GRAD_W-1] ? unsigned'(-grad.gx) : unsigned'(grad.gx);
      abs_gy      = grad.gy[sem_pkg::GRAD_W-1] ? unsigned'(-grad.gy) : unsigned'(grad.gy);
      mag_sum     = abs_gx + abs_gy;
      mag_clamped = (mag_sum > sem_pkg::GRAD_W'(255)) ? '1 : mag_sum[sem_pkg::PIX_W-1:0];
      push        = s2_tag_ff.emit;
      push_data.edge_value    = s2_tag_ff.use_window ? mag_clamped : '0;
      push_data.out_row       = s2_tag_ff.row;
      push_data.out_col       = s2_tag_ff.col;
      push_data.last_of_frame = s2_tag_ff.last;
   end

   sem_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= sem_pkg::PEND_W'(sem_pkg::RSP_DEPTH))
      else $error("Reserved result slots exceed the queue depth.");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("A queued result has no reserved slot.");

   a_emit_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> ##1 s2_tag_ff.emit)
      else $error("An emitting item did not reach the result queue.");

   a_drain_empty_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.func == sem_pkg::FUNC_DRAIN) && (owed_ff == '0))
      |=> !s1_tag_ff.emit)
      else $error("A drain with nothing owed produced a result.");

endmodule

FILE: sim/edge_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_stream_checker
// Watches the pixel, result and register ports of the Sobel edge magnitude
// stream. It keeps its own line stores, window and position counters, works
// out the result that each accepted pixel or drain transfer causes, and
// compares every accepted result transfer field by field with the oldest
// prediction. Register writes are followed so that the frame size is known,
// and register reads are checked against the last value written or reset.
// ----------------------------------------------------------------------------
module edge_stream_checker
   import sem_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    edges_pending,
   output int                    mismatch_count
);

   localparam int unsigned OWED_LIMIT = (1 << OWED_W) - 1;
   localparam int          EDGE_MAX   = (1 << PIX_W) - 1;

   logic [PIX_W-1:0]        upper_row_store  [MAX_WIDTH];
   logic [PIX_W-1:0]        middle_row_store [MAX_WIDTH];
   logic [PIX_W-1:0]        neighbourhood    [3][3];
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   logic [CSR_DATA_W-1:0]   register_value;
   int unsigned             in_col;
   int unsigned             in_row;
   int unsigned             owed_count;
   int unsigned             out_row_pos;
   int unsigned             out_col_pos;
   rsp_type                 expected_edges [$];
   rsp_type                 wanted;

   initial begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_row_store[i]  = '0;
         middle_row_store[i] = '0;
      end
   end

   function automatic int unsigned frame_cols();
      int unsigned w;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned frame_rows();
      int unsigned h;
      h = height_reg;
      if (h < 3) h = 3;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   function automatic logic [PIX_W-1:0] window_magnitude();
      int gx;
      int gy;
      int total;
      gx = int'(neighbourhood[0][0]) + 2 * int'(neighbourhood[1][0])
         + int'(neighbourhood[2][0]) - int'(neighbourhood[0][2])
         - 2 * int'(neighbourhood[1][2]) - int'(neighbourhood[2][2]);
      gy = int'(neighbourhood[0][0]) + 2 * int'(neighbourhood[0][1])
         + int'(neighbourhood[0][2]) - int'(neighbourhood[2][0])
         - 2 * int'(neighbourhood[2][1]) - int'(neighbourhood[2][2]);
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      total = gx + gy;
      if (total > EDGE_MAX) total = EDGE_MAX;
      return PIX_W'(total);
   endfunction

   // Border positions and drained positions always give zero.
   function automatic rsp_type next_position(input bit from_window);
      int unsigned cols;
      int unsigned rows;
      int unsigned r;
      int unsigned c;
      bit          interior;
      rsp_type     edge_out;
      cols = frame_cols();
      rows = frame_rows();
      r = out_row_pos;
      c = out_col_pos;
      interior = r >= 1 && r + 2 <= rows && c >= 1 && c + 2 <= cols;
      edge_out.edge_value    = (interior && from_window) ? window_magnitude() : '0;
      edge_out.out_row       = r[11:0];
      edge_out.out_col       = c[10:0];
      edge_out.last_of_frame = (r + 1 >= rows) && (c + 1 >= cols);
      if (c + 1 >= cols) begin
         out_col_pos = 0;
         out_row_pos = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
         out_col_pos = c + 1;
      end
      return edge_out;
   endfunction

   function automatic void predict_edge(input req_type item);
      int unsigned      cols;
      int unsigned      rows;
      int unsigned      c;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      cols = frame_cols();
      rows = frame_rows();
      if (item.func == FUNC_DRAIN) begin
         if (owed_count != 0) begin
            owed_count--;
            expected_edges.push_back(next_position(1'b0));
         end
         return;
      end
      c   = in_col;
      up  = '0;
      mid = '0;
      if (c < MAX_WIDTH) begin
         up  = upper_row_store[c];
         mid = middle_row_store[c];
         upper_row_store[c]  = mid;
         middle_row_store[c] = item.pixel;
      end
      for (int k = 0; k < 3; k++) begin
         neighbourhood[k][0] = neighbourhood[k][1];
         neighbourhood[k][1] = neighbourhood[k][2];
      end
      neighbourhood[0][2] = up;
      neighbourhood[1][2] = mid;
      neighbourhood[2][2] = item.pixel;
      if (c + 1 >= cols) begin
         in_col = 0;
         in_row = (in_row + 1 >= rows) ? 0 : in_row + 1;
      end else begin
         in_col = c + 1;
      end
      if (owed_count < OWED_LIMIT) owed_count++;
      if (owed_count > cols + 1) begin
         owed_count--;
         expected_edges.push_back(next_position(1'b1));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_reg   = WIDTH_REG_W'(640);
         height_reg  = HEIGHT_REG_W'(480);
         in_col      = 0;
         in_row      = 0;
         owed_count  = 0;
         out_row_pos = 0;
         out_col_pos = 0;
         for (int k = 0; k < 9; k++) begin
            neighbourhood[k / 3][k % 3] = '0;
         end
         expected_edges.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            register_value = '0;
            if (csr_paddr == CSR_ADDR_W'(4 * int'(CSR_FRAME_WIDTH))) begin
               if (csr_pwrite) width_reg = csr_pwdata[WIDTH_REG_W-1:0];
               register_value[WIDTH_REG_W-1:0] = width_reg;
            end else begin
               if (csr_pwrite) height_reg = csr_pwdata[HEIGHT_REG_W-1:0];
               register_value[HEIGHT_REG_W-1:0] = height_reg;
            end
            if (!csr_pwrite && csr_prdata !== register_value) begin
               $error("prdata at 0x%0h: expected 0x%0h, actual 0x%0h",
                      csr_paddr, register_value, csr_prdata);
               mismatch_count++;
            end
         end
         if (req_valid && !req_stall) predict_edge(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_edges.size() == 0) begin
               $error("result transfer with nothing predicted: row %0d col %0d value %0d",
                      rsp_data.out_row, rsp_data.out_col, rsp_data.edge_value);
               mismatch_count++;
            end else begin
               wanted = expected_edges.pop_front();
               if (rsp_data.edge_value !== wanted.edge_value) begin
                  $error("edge_value: expected %0d, actual %0d",
                         wanted.edge_value, rsp_data.edge_value);
                  mismatch_count++;
               end
               if (rsp_data.out_row !== wanted.out_row) begin
                  $error("out_row: expected %0d, actual %0d",
                         wanted.out_row, rsp_data.out_row);
                  mismatch_count++;
               end
               if (rsp_data.out_col !== wanted.out_col) begin
                  $error("out_col: expected %0d, actual %0d",
                         wanted.out_col, rsp_data.out_col);
                  mismatch_count++;
               end
               if (rsp_data.last_of_frame !== wanted.last_of_frame) begin
                  $error("last_of_frame: expected %0d, actual %0d",
                         wanted.last_of_frame, rsp_data.last_of_frame);
                  mismatch_count++;
               end
            end
         end
      end
      edges_pending = expected_edges.size();
   end

endmodule

FILE: sim/tb_sobel_edge_magnitude_stream_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_stream_top
// Stimulus and verdict for the Sobel edge magnitude stream. A first frame as
// wide as any later frame fills every line store entry that is read later; a
// short directed part then drives saturating gradients of both signs, an
// early drain and drains with nothing owed; random phases follow with new
// frame sizes, whole and partial frames, stray drains and random gaps on both
// channels. The checker beside the block predicts and compares every result
// transfer.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_stream_top;
   import sem_pkg::*;

   localparam int unsigned RANDOM_ITEMS    = 1700;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned WIDEST_FRAME    = 64;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    edges_pending;
   int                    mismatch_count;

   bit          sender_gaps      = 1'b0;
   bit          receiver_gaps    = 1'b0;
   bit          hold_off_request = 1'b0;
   int unsigned frame_cols       = 640;
   int unsigned frame_rows       = 480;
   int unsigned items_sent       = 0;

   // Two 3x3 frames whose centre gradients saturate with opposite signs.
   logic [PIX_W-1:0] steep_edges [18] = '{
      8'd255, 8'd255, 8'd0,   8'd255, 8'd0,   8'd0,   8'd0, 8'd0,   8'd0,
      8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0, 8'd255, 8'd255
   };

   sobel_edge_magnitude_stream_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   edge_stream_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .edges_pending  (edges_pending),
      .mismatch_count (mismatch_count)
   );

   always #5 clock = ~clock;

   function automatic int unsigned idle_span();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PIX_W-1:0] pixel_value();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic func, input logic [PIX_W-1:0] px);
      int unsigned gap;
      gap = sender_gaps ? idle_span() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{func: func, pixel: px};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_pixels(input int unsigned count, input int unsigned noise_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < noise_pct) send_item(FUNC_DRAIN, pixel_value());
         send_item(FUNC_PIXEL, pixel_value());
      end
   endtask

   task automatic send_drains(input int unsigned count);
      repeat (count) send_item(FUNC_DRAIN, pixel_value());
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (edges_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write transfer followed by a read-back of the same register.
   task automatic program_register(input csr_index_type idx,
                                   input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_frame(input int unsigned w, input int unsigned h);
      logic [CSR_DATA_W-1:0] value;
      wait_for_quiet();
      value = $urandom;
      value[WIDTH_REG_W-1:0] = w[WIDTH_REG_W-1:0];
      program_register(CSR_FRAME_WIDTH, value);
      value = $urandom;
      value[HEIGHT_REG_W-1:0] = h[HEIGHT_REG_W-1:0];
      program_register(CSR_FRAME_HEIGHT, value);
      frame_cols = (w < 3) ? 3 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      frame_rows = (h < 3) ? 3 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
   endtask

   initial begin
      int unsigned phase;
      int unsigned shape;
      int unsigned noise;
      int unsigned random_start;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;

      send_item(FUNC_DRAIN, '1);
      set_frame(WIDEST_FRAME, 3);
      send_pixels(frame_cols * frame_rows, 0);
      send_drains(frame_cols + 1);

      set_frame(0, 2);
      for (int i = 0; i < 18; i++) begin
         if (i == 14) send_item(FUNC_DRAIN, '0);
         send_item(FUNC_PIXEL, steep_edges[i]);
      end
      send_drains(frame_cols + 2);

      phase = 0;
      random_start = items_sent;
      while (items_sent < random_start + RANDOM_ITEMS) begin
         shape = (phase == 0) ? 9 : $urandom_range(0, 9);
         case (shape)
            0: set_frame($urandom_range(0, 2), $urandom_range(0, 2));
            1: set_frame($urandom_range(3, 6), $urandom_range(4096, 8191));
            2: set_frame($urandom_range(20, WIDEST_FRAME), $urandom_range(3, 6));
            default: set_frame($urandom_range(3, 12), $urandom_range(3, 10));
         endcase
         sender_gaps   = ($urandom_range(0, 3) != 0);
         receiver_gaps = ($urandom_range(0, 3) != 0);
         if (phase == 0) begin
            sender_gaps      = 1'b0;
            hold_off_request = 1'b1;
         end
         noise = ($urandom_range(0, 2) == 0) ? 5 : 0;
         if (shape == 1) begin
            send_pixels(frame_cols * $urandom_range(8, 30), noise);
         end else begin
            repeat ((frame_cols > 16) ? 1 : $urandom_range(1, 3)) begin
               send_pixels(frame_cols * frame_rows, noise);
            end
            if ($urandom_range(0, 3) == 0) begin
               send_pixels($urandom_range(1, frame_cols * frame_rows - 1), noise);
            end else begin
               send_drains(frame_cols + 1 + $urandom_range(0, 1));
            end
         end
         phase++;
      end

      wait_for_quiet();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      int unsigned span;
      forever begin
         @(negedge clock);
         span = 0;
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            span = HOLD_OFF_CYCLES;
         end else if (receiver_gaps) begin
            span = idle_span();
         end
         if (span > 0) begin
            rsp_stall <= 1'b1;
            repeat (span) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: sobel_edge_magnitude_stream_top.f
rtl/sem_pkg.sv
rtl/sem_line_window.sv
rtl/sem_rsp_fifo.sv
rtl/sobel_edge_magnitude_stream_top.sv
sim/edge_stream_checker.sv
sim/tb_sobel_edge_magnitude_stream_top.sv
